[design/mdt_pkg.sv]
`timescale 1ns / 1ps

package mdt_pkg;

  localparam int MAX_LEVELS = 10;
  localparam int DEPTH_BITS = 32;
  localparam int STORE_SIZE = (1 << MAX_LEVELS) - 1;
  localparam int IDX_W      = MAX_LEVELS;
  localparam int NODE_W     = MAX_LEVELS - 1;
  localparam int CNT_W      = MAX_LEVELS + 1;
  localparam int LVL_W      = 4;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = ((IDX_W + DEPTH_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DEPTH_BITS + 7) / 8) * 8;

  localparam logic [LVL_W-1:0] LEVELS_RESET = LVL_W'(MAX_LEVELS);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_PROP  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic {
    STAT_DONE  = 1'b0,
    STAT_RANGE = 1'b1
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_PRP_RD,
    S_PRP_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DEPTH_BITS-1:0] wdata;
    logic [IDX_W-1:0]      raddr_a;
    logic [IDX_W-1:0]      raddr_b;
  } store_req_t;

endpackage

[design/mdt_store.sv]
`timescale 1ns / 1ps

module mdt_store (
  input  logic                                clk,
  input  mdt_pkg::store_req_t                 req,
  output logic [mdt_pkg::DEPTH_BITS-1:0]      rd_a,
  output logic [mdt_pkg::DEPTH_BITS-1:0]      rd_b
);

  logic [mdt_pkg::DEPTH_BITS-1:0] mem [0:mdt_pkg::STORE_SIZE-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

[design/mdt_ctrl.sv]
`timescale 1ns / 1ps

module mdt_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mdt_pkg::LVL_W-1:0]            levels,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mdt_pkg::MODE_W-1:0]           in_tuser,
  input  logic [mdt_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic                                 out_tuser,
  output logic [mdt_pkg::OUT_DATA_W-1:0]       out_tdata,
  output mdt_pkg::store_req_t                  req,
  input  logic [mdt_pkg::DEPTH_BITS-1:0]       rd_a,
  input  logic [mdt_pkg::DEPTH_BITS-1:0]       rd_b
);

  mdt_pkg::state_t                    state_r, state_nxt;
  logic [mdt_pkg::IDX_W-1:0]          clr_r, clr_nxt;
  logic [mdt_pkg::NODE_W-1:0]         node_r, node_nxt;
  logic [mdt_pkg::DEPTH_BITS-1:0]     res_depth_r, res_depth_nxt;
  mdt_pkg::status_t                   res_stat_r, res_stat_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [mdt_pkg::DEPTH_BITS-1:0]     out_depth_r, out_depth_nxt;
  mdt_pkg::status_t                   out_stat_r, out_stat_nxt;

  mdt_pkg::mode_t                     mode;
  logic [mdt_pkg::IDX_W-1:0]          idx;
  logic [mdt_pkg::DEPTH_BITS-1:0]     val;
  logic [mdt_pkg::CNT_W-1:0]          nodes;
  logic                               in_range;
  logic [mdt_pkg::IDX_W-1:0]          left_addr;
  logic [mdt_pkg::IDX_W-1:0]          right_addr;
  logic [mdt_pkg::DEPTH_BITS-1:0]     max_val;

  assign mode       = mdt_pkg::mode_t'(in_tuser);
  assign idx        = in_tdata[mdt_pkg::IDX_W-1:0];
  assign val        = in_tdata[mdt_pkg::IDX_W +: mdt_pkg::DEPTH_BITS];
  assign nodes      = mdt_pkg::CNT_W'((mdt_pkg::CNT_W'(1) << levels) - mdt_pkg::CNT_W'(1));
  assign in_range   = {1'b0, idx} < nodes;
  assign left_addr  = {node_r, 1'b1};
  assign right_addr = {node_r, 1'b0} + mdt_pkg::IDX_W'(2);
  // shared compare unit, one internal node per pass
  assign max_val    = (rd_a < rd_b) ? rd_b : rd_a;

  assign in_tready  = (state_r == mdt_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = mdt_pkg::OUT_DATA_W'(out_depth_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdt_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    res_depth_r <= res_depth_nxt;
    res_stat_r  <= res_stat_nxt;
    out_depth_r <= out_depth_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    res_depth_nxt = res_depth_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_depth_nxt = out_depth_r;
    out_stat_nxt  = out_stat_r;
    req.we        = 1'b0;
    req.waddr     = idx;
    req.wdata     = val;
    req.raddr_a   = idx;
    req.raddr_b   = right_addr;

    case (state_r)
      mdt_pkg::S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_r;
        req.wdata = '0;
        clr_nxt   = clr_r + mdt_pkg::IDX_W'(1);
        if (clr_r == mdt_pkg::IDX_W'(mdt_pkg::STORE_SIZE - 1)) begin
          clr_nxt   = '0;
          state_nxt = mdt_pkg::S_IDLE;
        end
      end
      mdt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          res_depth_nxt = '0;
          res_stat_nxt  = mdt_pkg::STAT_DONE;
          state_nxt     = mdt_pkg::S_DONE;
          case (mode)
            mdt_pkg::MODE_WRITE: begin
              if (in_range) begin
                req.we = 1'b1;
              end else begin
                res_stat_nxt = mdt_pkg::STAT_RANGE;
              end
            end
            mdt_pkg::MODE_PROP: begin
              if (levels > mdt_pkg::LVL_W'(1)) begin
                // last internal node is 2^(levels-1) - 2
                node_nxt  = mdt_pkg::NODE_W'((mdt_pkg::CNT_W'(1) << (levels - mdt_pkg::LVL_W'(1)))
                            - mdt_pkg::CNT_W'(2));
                state_nxt = mdt_pkg::S_PRP_RD;
              end
            end
            mdt_pkg::MODE_READ: begin
              if (in_range) begin
                state_nxt = mdt_pkg::S_RD_WAIT;
              end else begin
                res_stat_nxt = mdt_pkg::STAT_RANGE;
              end
            end
            default: begin
              res_stat_nxt = mdt_pkg::STAT_DONE;
            end
          endcase
        end
      end
      mdt_pkg::S_RD_WAIT: begin
        res_depth_nxt = rd_a;
        state_nxt     = mdt_pkg::S_DONE;
      end
      mdt_pkg::S_PRP_RD: begin
        req.raddr_a = left_addr;
        req.raddr_b = right_addr;
        state_nxt   = mdt_pkg::S_PRP_WR;
      end
      mdt_pkg::S_PRP_WR: begin
        req.we    = 1'b1;
        req.waddr = mdt_pkg::IDX_W'(node_r);
        req.wdata = max_val;
        if (node_r == '0) begin
          state_nxt = mdt_pkg::S_DONE;
        end else begin
          node_nxt  = node_r - mdt_pkg::NODE_W'(1);
          state_nxt = mdt_pkg::S_PRP_RD;
        end
      end
      mdt_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_depth_nxt = res_depth_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = mdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mdt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/max_depth_tree_propagate.sv]
`timescale 1ns / 1ps
// steps: a write goes from S_IDLE to S_DONE, a read through S_RD_WAIT to S_DONE, and a propagate
// loops S_PRP_RD then S_PRP_WR per internal node before S_DONE; each waits in S_DONE for the output register
// throughput: one item at a time; a propagate spends a read state and a write state per
// internal node on the single store write port and its registered read ports
// reset: synchronous, active low; tree_levels returns to 10 and the node store is
// zeroed by a clearing pass over all 1023 entries, during which in_tready stays low
module max_depth_tree_propagate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mdt_pkg::LVL_W-1:0]       cfg_wdata,   // tree_levels
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mdt_pkg::MODE_W-1:0]      in_tuser,    // mode
  input  logic [mdt_pkg::IN_DATA_W-1:0]   in_tdata,    // node_index[9:0], depth_value[41:10], zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tuser,   // status
  output logic [mdt_pkg::OUT_DATA_W-1:0]  out_tdata    // read_depth
);

  logic [mdt_pkg::LVL_W-1:0]      levels_r, levels_nxt;
  logic [mdt_pkg::LVL_W-1:0]      levels_use;
  mdt_pkg::store_req_t            req;
  logic [mdt_pkg::DEPTH_BITS-1:0] rd_a;
  logic [mdt_pkg::DEPTH_BITS-1:0] rd_b;

  assign levels_nxt = cfg_we ? cfg_wdata : levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= mdt_pkg::LEVELS_RESET;
    end else begin
      levels_r <= levels_nxt;
    end
  end

  // zero means root only, values above the 10 levels the store holds saturate
  always_comb begin
    levels_use = levels_r;
    if (levels_r == '0) begin
      levels_use = mdt_pkg::LVL_W'(1);
    end else if (levels_r > mdt_pkg::LEVELS_RESET) begin
      levels_use = mdt_pkg::LEVELS_RESET;
    end
  end

  mdt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .levels     (levels_use),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .req        (req),
    .rd_a       (rd_a),
    .rd_b       (rd_b)
  );

  mdt_store u_store (
    .clk  (clk),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

endmodule

[design/mdt_checker.sv]
`timescale 1ns / 1ps

module mdt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic                             out_tuser,
  input logic [mdt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a rejected index never carries a depth
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("out of range result with nonzero depth");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid right after reset");

endmodule

bind max_depth_tree_propagate mdt_checker u_mdt_checker (.*);

[tb/sv/max_depth_tree_propagate_tb.sv]
`timescale 1ns / 1ps

module max_depth_tree_propagate_tb;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_COUNT   = 14;
  localparam int PHASE_ITEMS   = 82;
  localparam int PAD_W         = mdt_pkg::IN_DATA_W - mdt_pkg::IDX_W - mdt_pkg::DEPTH_BITS;
  localparam int MAX_PRINTED   = 50;

  typedef struct packed {
    logic [mdt_pkg::DEPTH_BITS-1:0] depth;
    mdt_pkg::status_t               status;
  } tree_result_t;

  // mirror of the node store plus the expected answers still owed by the block
  class max_tree_model;
    logic [mdt_pkg::DEPTH_BITS-1:0] node_depths [mdt_pkg::STORE_SIZE];
    logic [mdt_pkg::LVL_W-1:0]      levels_reg;
    tree_result_t                   owed_results [$];
    int unsigned                    error_count;

    function new();
      for (int i = 0; i < mdt_pkg::STORE_SIZE; i++) node_depths[i] = '0;
      levels_reg  = mdt_pkg::LEVELS_RESET;
      error_count = 0;
    endfunction

    function void set_levels(logic [mdt_pkg::LVL_W-1:0] value);
      levels_reg = value;
    endfunction

    // zero acts as one level, anything past the maximum saturates
    function int unsigned levels_in_use();
      if (levels_reg == 0) return 1;
      if (levels_reg > mdt_pkg::MAX_LEVELS) return mdt_pkg::MAX_LEVELS;
      return levels_reg;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    function void note_input(mdt_pkg::mode_t mode, logic [mdt_pkg::IDX_W-1:0] idx,
                             logic [mdt_pkg::DEPTH_BITS-1:0] value);
      int unsigned                    lv;
      int unsigned                    nodes;
      int unsigned                    k;
      int unsigned                    node;
      tree_result_t                   res;
      logic [mdt_pkg::DEPTH_BITS-1:0] left_d;
      logic [mdt_pkg::DEPTH_BITS-1:0] right_d;
      lv         = levels_in_use();
      nodes      = (1 << lv) - 1;
      res.depth  = '0;
      res.status = mdt_pkg::STAT_DONE;
      case (mode)
        mdt_pkg::MODE_WRITE: begin
          if (idx < nodes) node_depths[idx] = value;
          else res.status = mdt_pkg::STAT_RANGE;
        end
        mdt_pkg::MODE_PROP: begin
          // bottom-up sweep over internal nodes, last one first
          for (k = (1 << (lv - 1)) - 1; k > 0; k--) begin
            node = k - 1;
            if (2 * node + 2 < mdt_pkg::STORE_SIZE) begin
              left_d  = node_depths[2 * node + 1];
              right_d = node_depths[2 * node + 2];
              node_depths[node] = (left_d < right_d) ? right_d : left_d;
            end
          end
        end
        mdt_pkg::MODE_READ: begin
          if (idx < nodes) res.depth = node_depths[idx];
          else res.status = mdt_pkg::STAT_RANGE;
        end
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    task flag_mismatch(string msg);
      if (error_count < MAX_PRINTED) $display("mismatch @%0t: %s", $time, msg);
      error_count++;
    endtask

    task check_result(mdt_pkg::status_t got_status,
                      logic [mdt_pkg::DEPTH_BITS-1:0] got_depth);
      tree_result_t want;
      if (owed_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat status %0d depth %h",
                                got_status, got_depth));
        return;
      end
      want = owed_results.pop_front();
      if (got_status !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", got_status, want.status));
      if (got_depth !== want.depth)
        flag_mismatch($sformatf("read_depth got %h want %h", got_depth, want.depth));
    endtask
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [mdt_pkg::LVL_W-1:0]      cfg_wdata  = mdt_pkg::LEVELS_RESET;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [mdt_pkg::MODE_W-1:0]     in_tuser   = mdt_pkg::MODE_NOP;
  logic [mdt_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           out_tuser;
  logic [mdt_pkg::OUT_DATA_W-1:0] out_tdata;

  max_tree_model tree_model = new();

  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned items_sent   = 0;
  int unsigned stall_style  = 0;
  int unsigned style_left   = 0;
  int unsigned run_left     = 0;

  max_depth_tree_propagate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: switches between always ready, coin flip, sparse and long runs
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(100, 400);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          out_tready <= ~out_tready;
          run_left   <= $urandom_range(1, 12);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tree_model.check_result(mdt_pkg::status_t'(out_tuser),
                              out_tdata[mdt_pkg::DEPTH_BITS-1:0]);
  end

  function automatic logic [mdt_pkg::DEPTH_BITS-1:0] pick_depth();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // one input beat, with bursts of random length and random gaps between them
  task automatic send_beat(input mdt_pkg::mode_t mode, input logic [mdt_pkg::IDX_W-1:0] idx,
                           input logic [mdt_pkg::DEPTH_BITS-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{PAD_W{1'b0}}, value, idx};
    do @(posedge clk); while (!in_tready);
    tree_model.note_input(mode, idx, value);
    items_sent++;
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (tree_model.pending() != 0) @(posedge clk);
  endtask

  task automatic write_levels(input logic [mdt_pkg::LVL_W-1:0] value);
    wait_results_done();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tree_model.set_levels(value);
  endtask

  // writes into the tree, a propagate, then reads of the root and other nodes
  task automatic run_tree_sequence();
    int unsigned lv;
    int unsigned nodes;
    int unsigned leaf_lo;
    int unsigned n;
    int unsigned k;
    logic [mdt_pkg::IDX_W-1:0] idx;
    lv      = tree_model.levels_in_use();
    nodes   = (1 << lv) - 1;
    leaf_lo = (1 << (lv - 1)) - 1;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) != 0)
        idx = mdt_pkg::IDX_W'($urandom_range(leaf_lo, nodes - 1));
      else
        idx = mdt_pkg::IDX_W'($urandom_range(0, nodes - 1));
      send_beat(mdt_pkg::MODE_WRITE, idx, pick_depth());
    end
    send_beat(mdt_pkg::MODE_PROP, mdt_pkg::IDX_W'($urandom), $urandom);
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      idx = ($urandom_range(0, 1) == 0) ? '0 : mdt_pkg::IDX_W'($urandom_range(0, nodes - 1));
      send_beat(mdt_pkg::MODE_READ, idx, $urandom);
    end
  endtask

  initial begin
    logic [mdt_pkg::LVL_W-1:0] phase_levels [PHASE_COUNT];
    int unsigned               p;
    int unsigned               phase_start;
    int unsigned               n;
    phase_levels = '{4'd10, 4'd1, 4'd15, 4'd4, 4'd0, 4'd7, 4'd11, 4'd2,
                     4'd9, 4'd5, 4'd13, 4'd3, 4'd8, 4'd6};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // store clearing pass holds off input until done
    do @(posedge clk); while (!in_tready);

    write_levels(4'd10);
    send_beat(mdt_pkg::MODE_WRITE, 10'd0, '1);
    send_beat(mdt_pkg::MODE_WRITE, 10'd1022, 32'h8000_0001);
    send_beat(mdt_pkg::MODE_WRITE, 10'd1021, 32'h0001_0000);
    send_beat(mdt_pkg::MODE_READ, 10'd1022, '0);
    send_beat(mdt_pkg::MODE_READ, 10'd0, '1);
    send_beat(mdt_pkg::MODE_WRITE, 10'd1023, '1);
    send_beat(mdt_pkg::MODE_READ, 10'd1023, '0);
    send_beat(mdt_pkg::MODE_PROP, 10'd1023, '1);
    send_beat(mdt_pkg::MODE_READ, 10'd0, '0);
    send_beat(mdt_pkg::MODE_NOP, 10'd1023, '1);
    send_beat(mdt_pkg::MODE_WRITE, 10'd511, '1);
    send_beat(mdt_pkg::MODE_PROP, 10'd0, '0);
    send_beat(mdt_pkg::MODE_READ, 10'd0, '0);
    send_beat(mdt_pkg::MODE_READ, 10'd255, '0);
    write_levels(4'd1);
    send_beat(mdt_pkg::MODE_WRITE, 10'd0, 32'h1234_5678);
    send_beat(mdt_pkg::MODE_WRITE, 10'd1, '1);
    send_beat(mdt_pkg::MODE_PROP, 10'd0, '0);
    send_beat(mdt_pkg::MODE_READ, 10'd0, '0);
    send_beat(mdt_pkg::MODE_READ, 10'd1, '0);
    write_levels(4'd0);
    send_beat(mdt_pkg::MODE_READ, 10'd0, '0);
    send_beat(mdt_pkg::MODE_WRITE, 10'd1, '1);
    // saturated levels: entries outside the shrunk tree kept their values
    write_levels(4'd15);
    send_beat(mdt_pkg::MODE_READ, 10'd1022, '0);
    send_beat(mdt_pkg::MODE_PROP, 10'd0, '0);
    send_beat(mdt_pkg::MODE_READ, 10'd0, '0);

    for (p = 0; p < PHASE_COUNT; p++) begin
      write_levels(p < PHASE_COUNT - 2 ? phase_levels[p]
                                       : mdt_pkg::LVL_W'($urandom_range(0, 15)));
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          run_tree_sequence();
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) send_beat(mdt_pkg::mode_t'($urandom_range(0, 3)),
                               mdt_pkg::IDX_W'($urandom_range(0, 1023)), pick_depth());
        end
      end
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tree_model.error_count == 0 && tree_model.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
